>>> hdl/dlc_pkg.sv
// ----------------------------------------------------------------------------
// dlc_pkg: shared types and constants of the direct lag correlator
// Item layouts, action codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package dlc_pkg;

  localparam int ACTION_BITS = 2;
  localparam int FIELD_BITS  = 16;  // width of the sample fields of an input item
  localparam int LAG_BITS    = 10;
  localparam int LIMIT_BITS  = 11;  // origin_limit and origins_used
  localparam int ACC_BITS    = 64;  // accumulator wraps modulo 2^64
  localparam int QUOT_BITS   = 32;  // Q2.30 average
  localparam int CFG_BITS    = 11;  // widest register
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_LAG_RANGE = 1'b1
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CROSS_MODE   = 1'b0,
    REG_ORIGIN_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0]      action;
    logic signed [FIELD_BITS-1:0] sample_a;
    logic signed [FIELD_BITS-1:0] sample_b;
    logic [LAG_BITS-1:0]         lag;
  } in_item_t;

  typedef struct packed {
    logic signed [QUOT_BITS-1:0] average;
    logic [LIMIT_BITS-1:0]       origins_used;
    logic                        status;
  } out_item_t;

endpackage

>>> hdl/direct_lag_correlator_top.sv
// ----------------------------------------------------------------------------
// direct_lag_correlator_top: direct lagged auto/cross correlation of a stored series
// Sequencer, one shared multiply-accumulate unit and a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item when start is high and busy is low.
//   Append stores the pair (a, b) at the end of the series; dropped when full.
//   Clear empties the series. Neither produces a result, and busy stays low.
//   Query raises busy, walks the stored pairs with one MAC per cycle and
//   divides the sum by the origin count. One result item appears on result
//   for exactly one cycle with done high; the receiver cannot stall it.
//   A query runs through setup, the MAC issues, the pipeline drain, the
//   divider start and load, the divider steps and the output register;
//   a lag out of range ends at setup. The origin count is at most
//   MAX_FRAMES.
//   busy drops with done, so the next item can go in while done is high.
//   The MAC loop through the sample RAMs and the divider steps set the query time.
//   Config: cfg_we writes register cfg_index (0 cross_mode, 1 origin_limit);
//   the user writes only while the block is idle; the block does not enforce it.
//   Reset (rst, synchronous) empties the series and clears both registers;
//   sample memories are not cleared.
// ----------------------------------------------------------------------------
module direct_lag_correlator_top #(
  parameter int MAX_FRAMES  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  dlc_pkg::in_item_t               item,
  input  logic                            cfg_we,
  input  logic [dlc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [dlc_pkg::CFG_BITS-1:0]    cfg_data,
  output logic                            done,
  output dlc_pkg::out_item_t              result
);

  import dlc_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);       // RAM address
  localparam int LW = $clog2(MAX_FRAMES + 1);   // length / count / index
  localparam int CW = (LW > LIMIT_BITS) ? LW : LIMIT_BITS;  // compare width
  localparam int PW = 2 * SAMPLE_BITS;          // product width

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MAC,
    S_DIV
  } state_t;

  state_t state;

  // configuration
  logic                  cross_mode;
  logic [LIMIT_BITS-1:0] origin_limit;

  // series bookkeeping
  logic [LW-1:0]       length;
  logic [LAG_BITS-1:0] lag_q;
  logic [LW-1:0]       count;
  logic [LW-1:0]       idx;

  // MAC pipeline
  logic                    rd_v;
  logic                    prod_v;
  logic signed [PW-1:0]    prod;
  logic [ACC_BITS-1:0]     acc;

  // divider handshake
  logic                    div_start;
  logic                    div_done;
  logic [QUOT_BITS-1:0]    div_quot;

  // accept / write side
  logic                    accept;
  logic                    ram_we;
  logic [SAMPLE_BITS-1:0]  wr_a;
  logic [SAMPLE_BITS-1:0]  wr_b;

  // read side
  logic [AW-1:0]           rd_i;
  logic [AW-1:0]           rd_j;
  logic [LW-1:0]           j_sum;
  logic [SAMPLE_BITS-1:0]  a_i;
  logic [SAMPLE_BITS-1:0]  a_j;
  logic [SAMPLE_BITS-1:0]  b_j;
  logic [SAMPLE_BITS-1:0]  x_j;

  // setup arithmetic
  logic [CW-1:0]           diff;
  logic                    lag_err;
  logic [LW-1:0]           count_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (action_t'(item.action) == ACT_APPEND)
                  && (length != LW'(MAX_FRAMES));

  // low SAMPLE_BITS of the field; wider storage sees the field zero-extended
  assign wr_a = SAMPLE_BITS'($unsigned(item.sample_a));
  assign wr_b = SAMPLE_BITS'($unsigned(item.sample_b));

  // idx + lag stays below the length whenever the read is used
  assign j_sum = idx + LW'(lag_q);
  assign rd_i  = idx[AW-1:0];
  assign rd_j  = j_sum[AW-1:0];
  assign x_j   = cross_mode ? b_j : a_j;

  always_comb begin
    diff       = CW'(length) - CW'(lag_q);
    lag_err    = CW'(lag_q) >= CW'(length);
    count_next = LW'(diff);
    if ((origin_limit != '0) && (CW'(origin_limit) < diff)) begin
      count_next = LW'(origin_limit);
    end
  end

  // series a read at origin i
  dlc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_ram_a_origin (
    .clk   (clk),
    .we    (ram_we),
    .waddr (length[AW-1:0]),
    .wdata (wr_a),
    .raddr (rd_i),
    .rdata (a_i)
  );

  // copy of series a read at lagged index (auto mode operand)
  dlc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_ram_a_lagged (
    .clk   (clk),
    .we    (ram_we),
    .waddr (length[AW-1:0]),
    .wdata (wr_a),
    .raddr (rd_j),
    .rdata (a_j)
  );

  // series b read at lagged index (cross mode operand)
  dlc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_ram_b_lagged (
    .clk   (clk),
    .we    (ram_we),
    .waddr (length[AW-1:0]),
    .wdata (wr_b),
    .raddr (rd_j),
    .rdata (b_j)
  );

  dlc_divider #(.DIV_BITS(LW)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ($signed(acc)),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_mode   <= 1'b0;
      origin_limit <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CROSS_MODE:   cross_mode   <= cfg_data[0];
        REG_ORIGIN_LIMIT: origin_limit <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, MAC pipeline and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      done      <= 1'b0;
      div_start <= 1'b0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action_t'(item.action))
              ACT_APPEND: begin
                if (ram_we) begin
                  length <= length + 1'b1;
                end
              end
              ACT_CLEAR: length <= '0;
              ACT_QUERY: begin
                lag_q <= item.lag;
                state <= S_SETUP;
              end
              default: ;
            endcase
          end
        end

        S_SETUP: begin
          rd_v   <= 1'b0;
          prod_v <= 1'b0;
          acc    <= '0;
          idx    <= '0;
          count  <= count_next;
          if (lag_err) begin
            done                <= 1'b1;
            result.average      <= '0;
            result.origins_used <= '0;
            result.status       <= STATUS_LAG_RANGE;
            state               <= S_IDLE;
          end else begin
            state <= S_MAC;
          end
        end

        S_MAC: begin
          // issue -> RAM read -> product -> accumulate
          rd_v <= (idx != count);
          if (idx != count) begin
            idx <= idx + 1'b1;
          end
          prod   <= $signed(a_i) * $signed(x_j);
          prod_v <= rd_v;
          if (prod_v) begin
            acc <= acc + ACC_BITS'(prod);
          end
          if ((idx == count) && !rd_v && !prod_v) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            done                <= 1'b1;
            result.average      <= div_quot;
            result.origins_used <= LIMIT_BITS'(count);
            result.status       <= STATUS_OK;
            state               <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/dlc_ram.sv
// ----------------------------------------------------------------------------
// dlc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents undefined until written.
// ----------------------------------------------------------------------------
module dlc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dlc_divider.sv
// ----------------------------------------------------------------------------
// dlc_divider: signed-by-unsigned restoring divider
// One quotient bit per cycle over the accumulator width; truncates toward zero.
// ----------------------------------------------------------------------------
module dlc_divider #(
  parameter int DIV_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [dlc_pkg::ACC_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]                 divisor,
  output logic                                done,
  output logic [dlc_pkg::QUOT_BITS-1:0]       quotient
);

  import dlc_pkg::*;

  localparam int STEP_BITS = $clog2(ACC_BITS);

  logic                  running;
  logic [STEP_BITS-1:0]  step;
  logic                  neg;
  logic [DIV_BITS-1:0]   dvs;
  logic [DIV_BITS-1:0]   rem;
  logic [ACC_BITS-1:0]   q;

  logic [DIV_BITS:0]     shifted;
  logic                  ge;
  logic [DIV_BITS-1:0]   rem_next;
  logic [ACC_BITS-1:0]   q_next;
  logic [ACC_BITS-1:0]   mag;

  assign mag = dividend[ACC_BITS-1] ? (-dividend) : dividend;

  always_comb begin
    shifted  = {rem, q[ACC_BITS-1]};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? DIV_BITS'(shifted - {1'b0, dvs}) : DIV_BITS'(shifted);
    q_next   = {q[ACC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        neg     <= dividend[ACC_BITS-1];
        dvs     <= divisor;
        rem     <= '0;
        q       <= mag;
      end else if (running) begin
        rem  <= rem_next;
        q    <= q_next;
        step <= step + 1'b1;
        if (step == STEP_BITS'(ACC_BITS - 1)) begin
          running  <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? (-q_next[QUOT_BITS-1:0]) : q_next[QUOT_BITS-1:0];
        end
      end
    end
  end

endmodule
